/* rtl/mmvu_pkg.sv */
// shared types and constants for the maxwell memory variable update block
package mmvu_pkg;

  localparam int NUM_COMP   = 6;
  localparam int MAX_MECH   = 3;
  localparam int FACTOR_W   = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DEV_STAGES = 4;

  localparam logic [2:0] MEAN_DIV = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_2  = 3'd6;

  typedef struct packed {
    logic load_prod;
    logic load_upd;
    logic enable;
  } mmvu_lane_ctl_t;

endpackage

/* rtl/mmvu_deviator.sv */
// deviatoric stress pipeline: normal sum, reciprocal divide by three, mean removal
module mmvu_deviator #(
  parameter int SW = 32
) (
  input  logic                                  clk,
  input  logic [mmvu_pkg::DEV_STAGES-1:0]       load,
  input  logic [mmvu_pkg::NUM_COMP-1:0][SW-1:0] stress,
  output logic [mmvu_pkg::NUM_COMP-1:0][SW:0]   dev
);
  import mmvu_pkg::*;

  localparam int SUMW   = SW + 2;
  localparam int ABSW   = SW + 1;
  localparam int LO_W   = ABSW / 2;
  localparam int HI_W   = ABSW - LO_W;
  localparam int RCP_SH = SW + 3;
  localparam int RCP_W  = SW + 2;
  localparam int FULLW  = HI_W + RCP_W + LO_W + 1;
  localparam logic [63:0]      RCP_FULL = ((64'd1 << RCP_SH) + 64'd2) / 64'(MEAN_DIV);
  localparam logic [RCP_W-1:0] RCP      = RCP_FULL[RCP_W-1:0];

  logic [NUM_COMP-1:0][SW-1:0] s0_r;
  logic signed [SUMW-1:0]      sum0_r;
  logic signed [SUMW-1:0]      sum_nxt;
  logic [SUMW-1:0]             abs_v;
  logic [ABSW-1:0]             mag;

  logic [NUM_COMP-1:0][SW-1:0] s1_r;
  logic                        neg1_r;
  logic [HI_W+RCP_W-1:0]       ph_r;
  logic [LO_W+RCP_W-1:0]       pl_r;
  logic [FULLW-1:0]            full_v;

  logic [NUM_COMP-1:0][SW-1:0] s2_r;
  logic                        neg2_r;
  logic [SW:0]                 quo_r;

  logic [NUM_COMP-1:0][SW:0]   dev_r;
  logic [NUM_COMP-1:0][SW:0]   dev_nxt;

  assign sum_nxt = SUMW'($signed(stress[0])) + SUMW'($signed(stress[1]))
                 + SUMW'($signed(stress[2]));

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s0_r   <= stress;
      sum0_r <= sum_nxt;
    end
  end

  assign abs_v = sum0_r[SUMW-1] ? SUMW'(-sum0_r) : SUMW'(sum0_r);
  assign mag   = abs_v[ABSW-1:0];

  // magnitude times the rounded-up reciprocal of three, as two partial products
  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_r   <= s0_r;
      neg1_r <= sum0_r[SUMW-1];
      ph_r   <= (HI_W+RCP_W)'(mag[ABSW-1:LO_W] * RCP);
      pl_r   <= (LO_W+RCP_W)'(mag[LO_W-1:0] * RCP);
    end
  end

  assign full_v = FULLW'({ph_r, {LO_W{1'b0}}}) + FULLW'(pl_r);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_r   <= s1_r;
      neg2_r <= neg1_r;
      quo_r  <= full_v[RCP_SH +: SW+1];
    end
  end

  always_comb begin
    logic signed [SW:0] mean;
    logic [SW+1:0]      diff;
    mean = neg2_r ? -$signed(quo_r) : $signed(quo_r);
    for (int j = 0; j < NUM_COMP; j++) begin
      if (j < 3) begin
        diff = (SW+2)'($signed(s2_r[j])) - (SW+2)'(mean);
      end else begin
        diff = (SW+2)'($signed(s2_r[j]));
      end
      dev_nxt[j] = diff[SW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      dev_r <= dev_nxt;
    end
  end

  assign dev = dev_r;

endmodule

/* rtl/mmvu_lane.sv */
// one mechanism and component: gain product stage and memory variable recurrence
module mmvu_lane #(
  parameter int SW = 32,
  parameter int MW = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmvu_pkg::mmvu_lane_ctl_t      ctl,
  input  logic [mmvu_pkg::FACTOR_W-1:0] decay,
  input  logic [mmvu_pkg::FACTOR_W-1:0] gain,
  input  logic signed [SW:0]            dev,
  output logic signed [MW-1:0]          mem
);
  import mmvu_pkg::*;

  localparam int GW  = SW + 1 + FACTOR_W + 1;
  localparam int PW  = MW + FACTOR_W + 1;
  localparam int AW  = (PW > GW ? PW : GW) + 1;
  localparam int SHW = AW - FRAC_W;
  localparam logic signed [SHW-1:0] MEM_HI = {{(SHW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [SHW-1:0] MEM_LO = ~MEM_HI;

  logic signed [GW-1:0]  prod_r;
  logic signed [MW-1:0]  mem_r;
  logic signed [MW-1:0]  mem_nxt;
  logic signed [AW-1:0]  acc;
  logic signed [SHW-1:0] shifted;
  logic signed [MW-1:0]  sat_v;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r <= GW'(dev * $signed({1'b0, gain}));
    end
  end

  assign acc     = AW'(mem_r * $signed({1'b0, decay})) + AW'(prod_r);
  assign shifted = SHW'(acc >>> FRAC_W);

  always_comb begin
    if (shifted > MEM_HI) begin
      sat_v = MEM_HI[MW-1:0];
    end else if (shifted < MEM_LO) begin
      sat_v = MEM_LO[MW-1:0];
    end else begin
      sat_v = shifted[MW-1:0];
    end
    mem_nxt = ctl.enable ? sat_v : mem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r <= '0;
    end else if (ctl.load_upd) begin
      mem_r <= mem_nxt;
    end
  end

  assign mem = mem_r;

endmodule

/* rtl/mmvu_merge.sv */
// saturated sum of each component's mechanism lanes into output register; zero if disabled
module mmvu_merge #(
  parameter int NUM_MECH = 3,
  parameter int SW       = 32,
  parameter int MW       = 40
) (
  input  logic                                                clk,
  input  logic                                                load,
  input  logic                                                enable,
  input  logic [NUM_MECH-1:0][mmvu_pkg::NUM_COMP-1:0][MW-1:0] mem,
  output logic [mmvu_pkg::NUM_COMP-1:0][SW-1:0]               corr
);
  import mmvu_pkg::*;

  localparam int SMW  = MW + 2;
  localparam int MAXW = SMW > SW ? SMW : SW;
  localparam logic signed [MAXW-1:0] OUT_HI = {{(MAXW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [MAXW-1:0] OUT_LO = ~OUT_HI;

  logic [NUM_COMP-1:0][SW-1:0] corr_r;
  logic [NUM_COMP-1:0][SW-1:0] corr_nxt;

  always_comb begin
    logic signed [MAXW-1:0] acc;
    for (int j = 0; j < NUM_COMP; j++) begin
      acc = '0;
      for (int m = 0; m < NUM_MECH; m++) begin
        acc = acc + MAXW'($signed(mem[m][j]));
      end
      if (!enable) begin
        corr_nxt[j] = '0;
      end else if (acc > OUT_HI) begin
        corr_nxt[j] = OUT_HI[SW-1:0];
      end else if (acc < OUT_LO) begin
        corr_nxt[j] = OUT_LO[SW-1:0];
      end else begin
        corr_nxt[j] = acc[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corr_r <= corr_nxt;
    end
  end

  assign corr = corr_r;

endmodule

/* rtl/maxwell_memory_variable_update.sv */
// top level of the maxwell memory variable update block
// Accepts one six-component stress sample per clock while in_stall is low and returns one
// result per sample, in order. The deviatoric stress is formed in registered stages: the
// normal sum, two partial products of a reciprocal multiply that divides the sum by three,
// the quotient, and the mean removal; the gain product, the memory variable update and the
// output merge stages follow. The memory variable recurrence in each mechanism and
// component lane is one decay multiply and add into a single register, so samples stream
// at one per cycle while the output is not stalled. Each pipeline stage holds its own
// valid bit, so empty stages keep taking samples while a finished result waits behind a
// stalled output. Write the configuration only while no sample is in flight; with enable
// low every result is zero and the memory variables keep their values.
module maxwell_memory_variable_update #(
  parameter int NUM_MECH     = 3,
  parameter int STRESS_WIDTH = 32,
  parameter int MEMORY_WIDTH = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [STRESS_WIDTH-1:0]      in_stress_normal_0,
  input  logic signed [STRESS_WIDTH-1:0]      in_stress_normal_1,
  input  logic signed [STRESS_WIDTH-1:0]      in_stress_normal_2,
  input  logic signed [STRESS_WIDTH-1:0]      in_stress_shear_0,
  input  logic signed [STRESS_WIDTH-1:0]      in_stress_shear_1,
  input  logic signed [STRESS_WIDTH-1:0]      in_stress_shear_2,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [STRESS_WIDTH-1:0]      out_correction_normal_0,
  output logic signed [STRESS_WIDTH-1:0]      out_correction_normal_1,
  output logic signed [STRESS_WIDTH-1:0]      out_correction_normal_2,
  output logic signed [STRESS_WIDTH-1:0]      out_correction_shear_0,
  output logic signed [STRESS_WIDTH-1:0]      out_correction_shear_1,
  output logic signed [STRESS_WIDTH-1:0]      out_correction_shear_2,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmvu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmvu_pkg::FACTOR_W-1:0]       cfg_data
);
  import mmvu_pkg::*;

  localparam int NST     = DEV_STAGES + 3;
  localparam int ST_PROD = DEV_STAGES;
  localparam int ST_UPD  = DEV_STAGES + 1;
  localparam int ST_OUT  = DEV_STAGES + 2;

  logic                               enable_r;
  logic [MAX_MECH-1:0][FACTOR_W-1:0]  decay_r;
  logic [MAX_MECH-1:0][FACTOR_W-1:0]  gain_r;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] can_load;
  logic [NST-1:0] drain;
  logic [NST-1:0] load;

  logic [NUM_COMP-1:0][STRESS_WIDTH-1:0]                 stress_in;
  logic [NUM_COMP-1:0][STRESS_WIDTH:0]                   dev;
  logic [NUM_MECH-1:0][NUM_COMP-1:0][MEMORY_WIDTH-1:0]   mem_all;
  logic [NUM_COMP-1:0][STRESS_WIDTH-1:0]                 corr;
  mmvu_lane_ctl_t                                        lane_ctl;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      decay_r  <= '0;
      gain_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:  enable_r   <= cfg_data[0];
        REG_DECAY_0: decay_r[0] <= cfg_data;
        REG_DECAY_1: decay_r[1] <= cfg_data;
        REG_DECAY_2: decay_r[2] <= cfg_data;
        REG_GAIN_0:  gain_r[0]  <= cfg_data;
        REG_GAIN_1:  gain_r[1]  <= cfg_data;
        REG_GAIN_2:  gain_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage flow control
  always_comb begin
    drain[NST-1] = !out_stall;
    for (int k = NST - 1; k > 0; k--) begin
      can_load[k] = !vld_r[k] || drain[k];
      drain[k-1]  = can_load[k];
    end
    can_load[0] = !vld_r[0] || drain[0];
    load[0]     = can_load[0] && in_valid;
    for (int k = 1; k < NST; k++) begin
      load[k] = can_load[k] && vld_r[k-1];
    end
    vld_nxt = (vld_r & ~drain) | load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !can_load[0];
  assign out_valid = vld_r[NST-1];

  assign stress_in = {in_stress_shear_2, in_stress_shear_1, in_stress_shear_0,
                      in_stress_normal_2, in_stress_normal_1, in_stress_normal_0};

  mmvu_deviator #(
    .SW (STRESS_WIDTH)
  ) u_deviator (
    .clk    (clk),
    .load   (load[DEV_STAGES-1:0]),
    .stress (stress_in),
    .dev    (dev)
  );

  assign lane_ctl.load_prod = load[ST_PROD];
  assign lane_ctl.load_upd  = load[ST_UPD];
  assign lane_ctl.enable    = enable_r;

  for (genvar m = 0; m < NUM_MECH; m++) begin : g_mech
    for (genvar j = 0; j < NUM_COMP; j++) begin : g_comp
      mmvu_lane #(
        .SW (STRESS_WIDTH),
        .MW (MEMORY_WIDTH)
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lane_ctl),
        .decay (decay_r[m]),
        .gain  (gain_r[m]),
        .dev   ($signed(dev[j])),
        .mem   (mem_all[m][j])
      );
    end
  end

  mmvu_merge #(
    .NUM_MECH (NUM_MECH),
    .SW       (STRESS_WIDTH),
    .MW       (MEMORY_WIDTH)
  ) u_merge (
    .clk    (clk),
    .load   (load[ST_OUT]),
    .enable (enable_r),
    .mem    (mem_all),
    .corr   (corr)
  );

  assign out_correction_normal_0 = corr[0];
  assign out_correction_normal_1 = corr[1];
  assign out_correction_normal_2 = corr[2];
  assign out_correction_shear_0  = corr[3];
  assign out_correction_shear_1  = corr[4];
  assign out_correction_shear_2  = corr[5];

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !enable_r) |-> (corr == '0))
    else $error("nonzero correction while disabled");

  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !enable_r |=> $stable(mem_all))
    else $error("memory variables changed while disabled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted sample did not enter the pipeline");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(corr) && $stable(mem_all[0])
                                  || out_valid && $stable(corr)))
    else $error("stalled result was overwritten");

endmodule

/* sim/mmvu_correction_checker.sv */
// checker that predicts the correction transfers of the update block and compares them
`timescale 1ns / 100ps
module mmvu_correction_checker #(
  parameter int NUM_MECH = 3,
  parameter int STRESS_W = 32,
  parameter int MEM_W    = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [STRESS_W-1:0]          in_stress_normal_0,
  input  logic signed [STRESS_W-1:0]          in_stress_normal_1,
  input  logic signed [STRESS_W-1:0]          in_stress_normal_2,
  input  logic signed [STRESS_W-1:0]          in_stress_shear_0,
  input  logic signed [STRESS_W-1:0]          in_stress_shear_1,
  input  logic signed [STRESS_W-1:0]          in_stress_shear_2,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [STRESS_W-1:0]          out_correction_normal_0,
  input  logic signed [STRESS_W-1:0]          out_correction_normal_1,
  input  logic signed [STRESS_W-1:0]          out_correction_normal_2,
  input  logic signed [STRESS_W-1:0]          out_correction_shear_0,
  input  logic signed [STRESS_W-1:0]          out_correction_shear_1,
  input  logic signed [STRESS_W-1:0]          out_correction_shear_2,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mmvu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmvu_pkg::FACTOR_W-1:0]       cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import mmvu_pkg::*;

  typedef logic [NUM_COMP-1:0][STRESS_W-1:0] stress_set_t;

  stress_set_t           stress_in;
  stress_set_t           correction_out;
  stress_set_t           expected_corrections [$];
  logic                  enable_q;
  logic [FACTOR_W-1:0]   decay_q [MAX_MECH];
  logic [FACTOR_W-1:0]   gain_q [MAX_MECH];
  longint                memory_var [MAX_MECH][NUM_COMP];
  int                    fail_total = 0;
  int                    queued = 0;
  string                 field_name [NUM_COMP] = '{
    "correction_normal_0", "correction_normal_1", "correction_normal_2",
    "correction_shear_0", "correction_shear_1", "correction_shear_2"
  };

  assign stress_in = {in_stress_shear_2, in_stress_shear_1, in_stress_shear_0,
                      in_stress_normal_2, in_stress_normal_1, in_stress_normal_0};
  assign correction_out = {out_correction_shear_2, out_correction_shear_1,
                           out_correction_shear_0, out_correction_normal_2,
                           out_correction_normal_1, out_correction_normal_0};
  assign fail_count = fail_total;
  assign pending    = queued;

  function automatic longint saturate(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  task automatic predict_correction(input stress_set_t stress, output stress_set_t corr);
    longint s [NUM_COMP];
    longint dev [NUM_COMP];
    longint mean;
    longint upd;
    longint acc;
    corr = '0;
    if (!enable_q) return;
    for (int j = 0; j < NUM_COMP; j++) s[j] = longint'($signed(stress[j]));
    // mean of the normal components, truncated toward zero
    mean = (s[0] + s[1] + s[2]) / longint'(MEAN_DIV);
    for (int j = 0; j < NUM_COMP; j++) dev[j] = (j < 3) ? s[j] - mean : s[j];
    for (int m = 0; m < NUM_MECH; m++) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        upd = longint'(decay_q[m]) * memory_var[m][j] + longint'(gain_q[m]) * dev[j];
        memory_var[m][j] = saturate(upd >>> FRAC_W, MEM_W);
      end
    end
    for (int j = 0; j < NUM_COMP; j++) begin
      acc = 0;
      for (int m = 0; m < NUM_MECH; m++) acc += memory_var[m][j];
      corr[j] = STRESS_W'(saturate(acc, STRESS_W));
    end
  endtask

  always @(posedge clk) begin : watch
    stress_set_t predicted;
    stress_set_t wanted;
    if (!rst_n) begin
      enable_q = 1'b0;
      for (int m = 0; m < MAX_MECH; m++) begin
        decay_q[m] = '0;
        gain_q[m]  = '0;
        for (int j = 0; j < NUM_COMP; j++) memory_var[m][j] = 0;
      end
      expected_corrections.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:  enable_q   = cfg_data[0];
          REG_DECAY_0: decay_q[0] = cfg_data;
          REG_DECAY_1: decay_q[1] = cfg_data;
          REG_DECAY_2: decay_q[2] = cfg_data;
          REG_GAIN_0:  gain_q[0]  = cfg_data;
          REG_GAIN_1:  gain_q[1]  = cfg_data;
          REG_GAIN_2:  gain_q[2]  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_correction(stress_in, predicted);
        expected_corrections.insert(expected_corrections.size(), predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_corrections.size() == 0) begin
          $error("correction transfer with no prediction waiting");
          fail_total++;
        end else begin
          wanted = expected_corrections.pop_front();
          for (int j = 0; j < NUM_COMP; j++) begin
            if (correction_out[j] !== wanted[j]) begin
              $error("%s mismatch: expected %0d, actual %0d", field_name[j],
                     $signed(wanted[j]), $signed(correction_out[j]));
              fail_total++;
            end
          end
        end
      end
    end
    queued = expected_corrections.size();
  end

endmodule

/* sim/maxwell_memory_variable_update_test.sv */
// testbench top for the maxwell memory variable update block: stimulus, stalls and verdict
`timescale 1ns / 100ps
module maxwell_memory_variable_update_test;
  import mmvu_pkg::*;

  localparam int NUM_MECH     = 3;
  localparam int STRESS_W     = 32;
  localparam int MEM_W        = 40;
  localparam int LATENCY      = 7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1900;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [STRESS_W-1:0]  STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
  localparam logic [STRESS_W-1:0]  STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};
  localparam logic [STRESS_W-1:0]  STRESS_NEG1 = '1;
  localparam logic [STRESS_W-1:0]  STRESS_NEG2 = STRESS_NEG1 - 1'b1;
  localparam logic [FACTOR_W-1:0]  FACTOR_ONE = 17'd65536;
  localparam logic [FACTOR_W-1:0]  FACTOR_TOP = '1;

  typedef logic [NUM_COMP-1:0][STRESS_W-1:0] stress_set_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [STRESS_W-1:0] in_stress_normal_0;
  logic signed [STRESS_W-1:0] in_stress_normal_1;
  logic signed [STRESS_W-1:0] in_stress_normal_2;
  logic signed [STRESS_W-1:0] in_stress_shear_0;
  logic signed [STRESS_W-1:0] in_stress_shear_1;
  logic signed [STRESS_W-1:0] in_stress_shear_2;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [STRESS_W-1:0] out_correction_normal_0;
  logic signed [STRESS_W-1:0] out_correction_normal_1;
  logic signed [STRESS_W-1:0] out_correction_normal_2;
  logic signed [STRESS_W-1:0] out_correction_shear_0;
  logic signed [STRESS_W-1:0] out_correction_shear_1;
  logic signed [STRESS_W-1:0] out_correction_shear_2;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [FACTOR_W-1:0]        cfg_data;
  int                         fail_count;
  int                         pending;

  int                         burst_left = 0;
  int                         idle_cycles = 0;
  int                         stall_mode = 0;
  int                         stall_phase_left = 0;

  maxwell_memory_variable_update #(
    .NUM_MECH(NUM_MECH), .STRESS_WIDTH(STRESS_W), .MEMORY_WIDTH(MEM_W)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stress_normal_0(in_stress_normal_0), .in_stress_normal_1(in_stress_normal_1),
    .in_stress_normal_2(in_stress_normal_2), .in_stress_shear_0(in_stress_shear_0),
    .in_stress_shear_1(in_stress_shear_1), .in_stress_shear_2(in_stress_shear_2),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_correction_normal_0(out_correction_normal_0),
    .out_correction_normal_1(out_correction_normal_1),
    .out_correction_normal_2(out_correction_normal_2),
    .out_correction_shear_0(out_correction_shear_0),
    .out_correction_shear_1(out_correction_shear_1),
    .out_correction_shear_2(out_correction_shear_2),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mmvu_correction_checker #(
    .NUM_MECH(NUM_MECH), .STRESS_W(STRESS_W), .MEM_W(MEM_W)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stress_normal_0(in_stress_normal_0), .in_stress_normal_1(in_stress_normal_1),
    .in_stress_normal_2(in_stress_normal_2), .in_stress_shear_0(in_stress_shear_0),
    .in_stress_shear_1(in_stress_shear_1), .in_stress_shear_2(in_stress_shear_2),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_correction_normal_0(out_correction_normal_0),
    .out_correction_normal_1(out_correction_normal_1),
    .out_correction_normal_2(out_correction_normal_2),
    .out_correction_shear_0(out_correction_shear_0),
    .out_correction_shear_1(out_correction_shear_1),
    .out_correction_shear_2(out_correction_shear_2),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern: no stall, light, heavy, and long holds
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(20, 200);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL maxwell_memory_variable_update");
      $finish;
    end
  end

  function automatic stress_set_t make_set(
    input logic [STRESS_W-1:0] n0, n1, n2, s0, s1, s2
  );
    return {s2, s1, s0, n2, n1, n0};
  endfunction

  function automatic logic [STRESS_W-1:0] pick_stress();
    case ($urandom_range(0, 7))
      0:       return STRESS_MAX;
      1:       return STRESS_MIN;
      2, 3:    return STRESS_W'(32'($urandom_range(0, 4000)) - 32'd2000);
      default: return STRESS_W'($urandom);
    endcase
  endfunction

  function automatic stress_set_t pick_set();
    return make_set(pick_stress(), pick_stress(), pick_stress(),
                    pick_stress(), pick_stress(), pick_stress());
  endfunction

  function automatic logic [FACTOR_W-1:0] pick_factor();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FACTOR_ONE;
      2:       return FACTOR_TOP;
      3:       return FACTOR_W'($urandom);
      default: return FACTOR_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_stress(input stress_set_t s);
    @(negedge clk);
    in_valid           <= 1'b1;
    in_stress_normal_0 <= s[0];
    in_stress_normal_1 <= s[1];
    in_stress_normal_2 <= s[2];
    in_stress_shear_0  <= s[3];
    in_stress_shear_1  <= s[4];
    in_stress_shear_2  <= s[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(
    input logic en,
    input logic [FACTOR_W-1:0] d0, d1, d2, g0, g1, g2
  );
    logic [FACTOR_W-1:0] en_word;
    en_word    = FACTOR_W'($urandom);
    en_word[0] = en;
    write_reg(REG_ENABLE, en_word);
    write_reg(REG_DECAY_0, d0);
    write_reg(REG_DECAY_1, d1);
    write_reg(REG_DECAY_2, d2);
    write_reg(REG_GAIN_0, g0);
    write_reg(REG_GAIN_1, g1);
    write_reg(REG_GAIN_2, g2);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    int total;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_stress_normal_0 = '0;
    in_stress_normal_1 = '0;
    in_stress_normal_2 = '0;
    in_stress_shear_0  = '0;
    in_stress_shear_1  = '0;
    in_stress_shear_2  = '0;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled after reset
    send_stress(make_set(STRESS_MAX, STRESS_MAX, STRESS_MAX,
                         STRESS_MAX, STRESS_MAX, STRESS_MAX));
    send_stress(make_set(STRESS_MIN, STRESS_MIN, STRESS_MIN,
                         STRESS_MIN, STRESS_MIN, STRESS_MIN));
    drain();

    // unit decay and gain, extremes and mean truncation toward zero
    load_settings(1'b1, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE,
                  FACTOR_ONE, FACTOR_ONE, FACTOR_ONE);
    write_reg(REG_UNMAPPED, FACTOR_TOP);
    send_stress(make_set(STRESS_MAX, STRESS_MAX, STRESS_MAX,
                         STRESS_MAX, STRESS_MAX, STRESS_MAX));
    send_stress(make_set(STRESS_MIN, STRESS_MIN, STRESS_MIN,
                         STRESS_MIN, STRESS_MIN, STRESS_MIN));
    send_stress(make_set(STRESS_MAX, STRESS_MIN, '0, 32'd1, STRESS_NEG1, '0));
    send_stress(make_set(STRESS_NEG1, STRESS_NEG1, '0, '0, '0, '0));
    send_stress(make_set(STRESS_NEG2, STRESS_NEG2, STRESS_NEG1, '0, '0, '0));
    drain();

    // factors above one drive the memory variables into saturation both ways
    load_settings(1'b1, FACTOR_TOP, FACTOR_TOP, FACTOR_TOP,
                  FACTOR_TOP, FACTOR_TOP, FACTOR_TOP);
    repeat (6) send_stress(make_set(STRESS_MAX, STRESS_MIN, STRESS_MIN,
                                    STRESS_MAX, STRESS_MAX, STRESS_MAX));
    repeat (6) send_stress(make_set(STRESS_MIN, STRESS_MAX, STRESS_MAX,
                                    STRESS_MIN, STRESS_MIN, STRESS_MIN));
    drain();

    // disabled holds state, then unit decay with zero gain shows the held values
    load_settings(1'b0, FACTOR_ONE, '0, FACTOR_TOP, '0, FACTOR_ONE, FACTOR_TOP);
    send_stress(make_set(STRESS_MAX, '0, STRESS_MIN, STRESS_MAX, '0, STRESS_MIN));
    send_stress(pick_set());
    drain();
    load_settings(1'b1, FACTOR_ONE, FACTOR_ONE, FACTOR_ONE, '0, '0, '0);
    send_stress(pick_set());
    send_stress(pick_set());

    total = 0;
    while (total < RANDOM_ITEMS) begin
      drain();
      load_settings($urandom_range(0, 7) != 0, pick_factor(), pick_factor(), pick_factor(),
                    pick_factor(), pick_factor(), pick_factor());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, FACTOR_W'($urandom));
      n = $urandom_range(20, 150);
      repeat (n) send_stress(pick_set());
      total += n;
    end

    drain();
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0)
      $display("PASS maxwell_memory_variable_update");
    else
      $display("FAIL maxwell_memory_variable_update");
    $finish;
  end

endmodule
